// ===== hw/rtl/tga_rle_pkg.sv =====
// Shared types, codes and constants of the TGA run-length decoder.
package tga_rle_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_BPP    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic [2:0]  BPP_RESET      = 3'd4;
    localparam logic [2:0]  BPP_MIN        = 3'd1;
    localparam logic [2:0]  BPP_MAX        = 3'd4;
    localparam logic [15:0] DIM_RESET      = 16'd1;
    localparam logic [2:0]  COPIES_PER_BEAT = 3'd4;
    localparam logic [7:0]  HDR_COUNT_MASK = 8'h7F;
    localparam logic [7:0]  HDR_RUN_FLAG   = 8'h80;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_OVERRUN   = 2'd1;
    localparam logic [1:0] ERR_EARLY_END = 2'd2;

    typedef enum logic [1:0] {
        S_HEADER,
        S_PIXEL,
        S_DROP,
        S_RUN
    } state_t;

    typedef enum logic [2:0] {
        OUT_NONE,
        OUT_RAW,
        OUT_BEAT,
        OUT_ERR_OVR,
        OUT_ERR_EARLY
    } out_kind_t;

    typedef struct packed {
        logic      load_header;
        logic      gather;
        logic      finish;
        logic      run_beat;
        logic      new_image;
        out_kind_t out_kind;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic overrun;
        logic complete;
        logic done_now;
        logic is_run;
        logic left_one;
        logic left_le4;
        logic run_done;
        logic out_free;
        logic cfg_settle;
    } status_t;

endpackage

// ===== hw/rtl/tga_rle_if.sv =====
// Handshake channel interfaces for compressed bytes, decoded beats and configuration.
interface tga_rle_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface tga_rle_beat_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_value;
    logic [2:0]  copy_count;
    logic        image_done;
    logic [1:0]  error_code;

    modport source (output valid, output pixel_value, output copy_count,
                    output image_done, output error_code, input ready);
    modport sink (input valid, input pixel_value, input copy_count,
                  input image_done, input error_code, output ready);
endinterface

interface tga_rle_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/tga_rle_ctrl.sv =====
// Packet-level state machine of the TGA run-length decoder.
module tga_rle_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tga_rle_pkg::status_t status,
    output tga_rle_pkg::cmd_t    cmd
);
    import tga_rle_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg != S_RUN) && status.out_free && !status.cfg_settle;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_HEADER;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_HEADER:
            begin
                if (accept)
                begin
                    if (status.overrun)
                    begin
                        state_next = status.last ? S_HEADER : S_DROP;
                    end
                    else if (!status.last)
                    begin
                        state_next = S_PIXEL;
                    end
                end
            end
            S_DROP:
            begin
                if (accept && status.last)
                begin
                    state_next = S_HEADER;
                end
            end
            S_PIXEL:
            begin
                if (accept)
                begin
                    if (!status.complete)
                    begin
                        if (status.last)
                        begin
                            state_next = S_HEADER;
                        end
                    end
                    else if (status.last && !status.done_now)
                    begin
                        state_next = S_HEADER;
                    end
                    else if (status.is_run)
                    begin
                        state_next = S_RUN;
                    end
                    else if (status.done_now || status.left_one)
                    begin
                        state_next = S_HEADER;
                    end
                end
            end
            S_RUN:
            begin
                if (status.out_free && status.left_le4)
                begin
                    state_next = S_HEADER;
                end
            end
            default:
            begin
                state_next = S_HEADER;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.out_kind = OUT_NONE;
        case (state_reg)
            S_HEADER:
            begin
                if (accept)
                begin
                    if (status.overrun)
                    begin
                        cmd.out_kind  = OUT_ERR_OVR;
                        cmd.new_image = status.last;
                    end
                    else if (status.last)
                    begin
                        cmd.out_kind  = OUT_ERR_EARLY;
                        cmd.new_image = 1'b1;
                    end
                    else
                    begin
                        cmd.load_header = 1'b1;
                    end
                end
            end
            S_DROP:
            begin
                if (accept && status.last)
                begin
                    cmd.new_image = 1'b1;
                end
            end
            S_PIXEL:
            begin
                if (accept)
                begin
                    if (!status.complete)
                    begin
                        if (status.last)
                        begin
                            cmd.out_kind  = OUT_ERR_EARLY;
                            cmd.new_image = 1'b1;
                        end
                        else
                        begin
                            cmd.gather = 1'b1;
                        end
                    end
                    else if (status.last && !status.done_now)
                    begin
                        cmd.out_kind  = OUT_ERR_EARLY;
                        cmd.new_image = 1'b1;
                    end
                    else if (status.is_run)
                    begin
                        cmd.finish = 1'b1;
                    end
                    else
                    begin
                        cmd.finish    = 1'b1;
                        cmd.out_kind  = OUT_RAW;
                        cmd.new_image = status.done_now;
                    end
                end
            end
            S_RUN:
            begin
                if (status.out_free)
                begin
                    cmd.run_beat  = 1'b1;
                    cmd.out_kind  = OUT_BEAT;
                    cmd.new_image = status.left_le4 && status.run_done;
                end
            end
            default:
            begin
                cmd.out_kind = OUT_NONE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/tga_rle_dp.sv =====
// Datapath of the TGA run-length decoder: registers, pixel assembly, counters and output stage.
module tga_rle_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tga_rle_pkg::cmd_t    cmd,
    output tga_rle_pkg::status_t status,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [tga_rle_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tga_rle_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [31:0]          pixel_value,
    output logic [2:0]           copy_count,
    output logic                 image_done,
    output logic [1:0]           error_code
);
    import tga_rle_pkg::*;

    logic [2:0]  bpp_reg;
    logic [15:0] width_reg;
    logic [15:0] height_reg;
    logic [31:0] total_reg;
    logic        cfg_settle_reg;

    logic [7:0]  packet_left_reg;
    logic [7:0]  packet_left_next;
    logic        is_run_reg;
    logic        is_run_next;
    logic [1:0]  byte_index_reg;
    logic [1:0]  byte_index_next;
    logic [31:0] pixel_gather_reg;
    logic [31:0] pixel_gather_next;
    logic [31:0] pixels_done_reg;
    logic [31:0] pixels_done_next;
    logic        done_reg;

    logic        out_valid_reg;
    logic [31:0] pixel_value_reg;
    logic [2:0]  copy_count_reg;
    logic        image_done_reg;
    logic [1:0]  error_code_reg;

    logic [2:0]  bpp_clamp;
    logic [1:0]  index_inc;
    logic [31:0] gather_with_byte;
    logic [7:0]  hdr_count;
    logic [32:0] hdr_sum;
    logic [31:0] done_sum;
    logic [2:0]  beat_count;
    logic        cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid;

    always_comb
    begin
        if (bpp_reg < BPP_MIN)
        begin
            bpp_clamp = BPP_MIN;
        end
        else if (bpp_reg > BPP_MAX)
        begin
            bpp_clamp = BPP_MAX;
        end
        else
        begin
            bpp_clamp = bpp_reg;
        end
    end

    assign index_inc        = byte_index_reg + 2'd1;
    assign gather_with_byte = pixel_gather_reg
                            | ({24'd0, in_byte} << {byte_index_reg, 3'b000});
    assign hdr_count        = (in_byte & HDR_COUNT_MASK) + 8'd1;
    assign hdr_sum          = {1'b0, pixels_done_reg} + {25'd0, hdr_count};
    assign done_sum         = is_run_reg ? pixels_done_reg + {24'd0, packet_left_reg}
                                         : pixels_done_reg + 32'd1;
    assign beat_count       = status.left_le4 ? packet_left_reg[2:0] : COPIES_PER_BEAT;

    always_comb
    begin
        status.last       = in_last;
        status.overrun    = hdr_sum > {1'b0, total_reg};
        status.complete   = (index_inc == 2'd0) || ({1'b0, index_inc} >= bpp_clamp);
        status.done_now   = done_sum == total_reg;
        status.is_run     = is_run_reg;
        status.left_one   = packet_left_reg == 8'd1;
        status.left_le4   = packet_left_reg <= {5'd0, COPIES_PER_BEAT};
        status.run_done   = done_reg;
        status.out_free   = !out_valid_reg || out_ready;
        status.cfg_settle = cfg_settle_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg        <= BPP_RESET;
            width_reg      <= DIM_RESET;
            height_reg     <= DIM_RESET;
            total_reg      <= 32'd1;
            cfg_settle_reg <= 1'b0;
        end
        else
        begin
            cfg_settle_reg <= cfg_write;
            total_reg      <= {16'd0, width_reg} * {16'd0, height_reg};
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_BPP:    bpp_reg    <= cfg_data[2:0];
                    REG_WIDTH:  width_reg  <= cfg_data;
                    REG_HEIGHT: height_reg <= cfg_data;
                    default:    bpp_reg    <= bpp_reg;
                endcase
            end
        end
    end

    always_comb
    begin
        packet_left_next  = packet_left_reg;
        is_run_next       = is_run_reg;
        byte_index_next   = byte_index_reg;
        pixel_gather_next = pixel_gather_reg;
        pixels_done_next  = pixels_done_reg;
        if (cmd.new_image)
        begin
            packet_left_next  = 8'd0;
            is_run_next       = 1'b0;
            byte_index_next   = 2'd0;
            pixel_gather_next = 32'd0;
            pixels_done_next  = 32'd0;
        end
        else if (cmd.load_header)
        begin
            packet_left_next  = hdr_count;
            is_run_next       = (in_byte & HDR_RUN_FLAG) != 8'd0;
            byte_index_next   = 2'd0;
            pixel_gather_next = 32'd0;
        end
        else if (cmd.finish)
        begin
            byte_index_next   = 2'd0;
            pixels_done_next  = done_sum;
            pixel_gather_next = is_run_reg ? gather_with_byte : 32'd0;
            if (!is_run_reg)
            begin
                packet_left_next = packet_left_reg - 8'd1;
            end
        end
        else if (cmd.gather)
        begin
            byte_index_next   = index_inc;
            pixel_gather_next = gather_with_byte;
        end
        else if (cmd.run_beat)
        begin
            packet_left_next = packet_left_reg - {5'd0, beat_count};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_left_reg  <= 8'd0;
            is_run_reg       <= 1'b0;
            byte_index_reg   <= 2'd0;
            pixel_gather_reg <= 32'd0;
            pixels_done_reg  <= 32'd0;
            done_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            packet_left_reg  <= packet_left_next;
            is_run_reg       <= is_run_next;
            byte_index_reg   <= byte_index_next;
            pixel_gather_reg <= pixel_gather_next;
            pixels_done_reg  <= pixels_done_next;
            if (cmd.finish)
            begin
                done_reg <= status.done_now;
            end
            if (cmd.out_kind != OUT_NONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.out_kind)
            OUT_RAW:
            begin
                pixel_value_reg <= gather_with_byte;
                copy_count_reg  <= 3'd1;
                image_done_reg  <= status.done_now;
                error_code_reg  <= ERR_NONE;
            end
            OUT_BEAT:
            begin
                pixel_value_reg <= pixel_gather_reg;
                copy_count_reg  <= beat_count;
                image_done_reg  <= status.left_le4 && done_reg;
                error_code_reg  <= ERR_NONE;
            end
            OUT_ERR_OVR:
            begin
                pixel_value_reg <= 32'd0;
                copy_count_reg  <= 3'd0;
                image_done_reg  <= 1'b0;
                error_code_reg  <= ERR_OVERRUN;
            end
            OUT_ERR_EARLY:
            begin
                pixel_value_reg <= 32'd0;
                copy_count_reg  <= 3'd0;
                image_done_reg  <= 1'b0;
                error_code_reg  <= ERR_EARLY_END;
            end
            default:
            begin
                pixel_value_reg <= pixel_value_reg;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign pixel_value = pixel_value_reg;
    assign copy_count  = copy_count_reg;
    assign image_done  = image_done_reg;
    assign error_code  = error_code_reg;

endmodule

// ===== hw/rtl/tga_rle_decoder_core.sv =====
// Top level of the TGA run-length decoder.
// The decoder takes one compressed byte per cycle and returns decoded pixels as beats of up
// to four copies. A header byte or a byte of a raw pixel leads to no extra state; the byte
// that completes a run pixel is followed by state S_RUN, in which the output register sends
// the run out in ceil(count/4) beats and no byte is taken. The cycle after a configuration
// transfer takes no byte while the registered pixel total width*height is updated. Input
// waits whenever the output register holds a beat that is not being taken.
module tga_rle_decoder_core (
    input logic           clk,
    input logic           rst_n,
    tga_rle_byte_if.sink  stream,
    tga_rle_beat_if.source pixels,
    tga_rle_cfg_if.sink   cfg
);
    import tga_rle_pkg::*;

    cmd_t    cmd;
    status_t status;

    tga_rle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stream.valid),
        .in_ready (stream.ready),
        .status   (status),
        .cmd      (cmd)
    );

    tga_rle_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_byte     (stream.in_byte),
        .in_last     (stream.in_last),
        .cfg_valid   (cfg.valid),
        .cfg_ready   (cfg.ready),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .out_valid   (pixels.valid),
        .out_ready   (pixels.ready),
        .pixel_value (pixels.pixel_value),
        .copy_count  (pixels.copy_count),
        .image_done  (pixels.image_done),
        .error_code  (pixels.error_code)
    );

    // An error beat carries no pixel, no copies and no end-of-image flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixels.valid && (pixels.error_code != ERR_NONE)
        |-> (pixels.pixel_value == 32'd0) && (pixels.copy_count == 3'd0)
            && !pixels.image_done)
        else $error("error beat carries pixel data");

    // A pixel beat stands for one to four copies.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixels.valid && (pixels.error_code == ERR_NONE)
        |-> (pixels.copy_count != 3'd0) && (pixels.copy_count <= COPIES_PER_BEAT))
        else $error("pixel beat with bad copy count");

    // No byte is taken in the cycle after a configuration transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid && cfg.ready |=> !(stream.valid && stream.ready))
        else $error("byte taken before pixel total settled");

    // A new beat is never loaded over one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixels.valid && !pixels.ready |-> cmd.out_kind == OUT_NONE)
        else $error("output beat overwritten");

endmodule
